// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the queue block.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define SFQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfq check failed");

// Cause in one cycle, effect in the next
`define SFQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfq check failed");

`endif

// ----- sv/sfq_pkg.sv -----
// Package of the sortable queue: payload types, codes, control structs.
// Depends on nothing.
`default_nettype none

package sfq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    // Operation codes
    localparam logic [2:0] OP_ENQ  = 3'd0;
    localparam logic [2:0] OP_DEQ  = 3'd1;
    localparam logic [2:0] OP_SHOW = 3'd2;
    localparam logic [2:0] OP_REV  = 3'd3;
    localparam logic [2:0] OP_FIND = 3'd4;
    localparam logic [2:0] OP_SORT = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] word;
        logic [4:0]         position;
        logic               last;
    } res_t;

    // Controller to datapath
    typedef struct packed {
        logic enq;        // append request value, answer ok or full
        logic empty_res;  // answer queue empty
        logic deq_rd;     // read front entry
        logic deq_done;   // answer with front entry, pop it
        logic scan_init;  // latch op and key, clear walk counter
        logic scan_rd;    // read next entry of the walk
        logic flush;      // final search answer
        logic sort_init;  // clear outer sort index
        logic sort_rdk;   // read outer entry
        logic sort_ldk;   // load outer entry, read inner entry
        logic sort_cmp;   // compare and swap inner entry
        logic sort_wrk;   // write back outer entry
        logic sort_done;  // answer sort ok
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic ge2;        // at least two entries
        logic k_last;     // walk index at last entry
        logic m_last;     // inner sort index at last entry
        logic ks_last;    // outer sort index at last pass
        logic find;       // current walk is a search
    } sts_t;

endpackage

`default_nettype wire

// ----- sv/sortable_fifo_queue_with_search_core.sv -----
// Top level of the sortable queue with search: controller plus datapath.
// Depends on sfq_pkg, sfq_ctrl, sfq_dp (and through it sfq_ram).
//
//   channel   handshake           payload            direction
//   request   start / busy        request (req_t)    in
//   result    strobe (1 cycle)    result (res_t)     out
//
// Enqueue, and any answer that needs no RAM read, shows its result in the
// cycle after acceptance and leaves busy low. Dequeue holds busy for a
// registered RAM read; display and reverse hold it while walking the entries,
// search also for a flush. Sort of N >= 2 entries holds it over outer passes
// of read, load, compares and write-back. The last result shows as busy
// drops. Reset clears pointers and control only; results cannot be held off.
`default_nettype none

module sortable_fifo_queue_with_search_core #(
    parameter int DEPTH = sfq_pkg::DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sfq_pkg::req_t request,
    output logic               strobe,
    output sfq_pkg::res_t      result
);

    sfq_pkg::cmd_t cmd;
    sfq_pkg::sts_t sts;

    sfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .sts       (sts),
        .busy      (busy),
        .cmd       (cmd)
    );

    sfq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

`default_nettype wire

// ----- sv/sfq_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`default_nettype none

module sfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/sfq_ctrl.sv -----
// Controller of the sortable queue: sequences walks, dequeue and sort.
// Depends on sfq_pkg.
`default_nettype none

module sfq_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [2:0]   operation,
    input  wire sfq_pkg::sts_t sts,
    output logic              busy,
    output sfq_pkg::cmd_t     cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DEQ_WAIT = 9'b000000010,
        S_SCAN     = 9'b000000100,
        S_SCAN_END = 9'b000001000,
        S_FLUSH    = 9'b000010000,
        S_SORT_RDK = 9'b000100000,
        S_SORT_LDK = 9'b001000000,
        S_SORT_CMP = 9'b010000000,
        S_SORT_WRK = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (operation) inside
                        sfq_pkg::OP_ENQ:
                        begin
                            cmd.enq = 1'b1;
                        end
                        sfq_pkg::OP_DEQ:
                        begin
                            if (sts.empty)
                            begin
                                cmd.empty_res = 1'b1;
                            end
                            else
                            begin
                                cmd.deq_rd = 1'b1;
                                state_next = S_DEQ_WAIT;
                            end
                        end
                        sfq_pkg::OP_SHOW, sfq_pkg::OP_REV, sfq_pkg::OP_FIND:
                        begin
                            if (sts.empty)
                            begin
                                cmd.empty_res = 1'b1;
                            end
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        sfq_pkg::OP_SORT:
                        begin
                            if (sts.ge2)
                            begin
                                cmd.sort_init = 1'b1;
                                state_next    = S_SORT_RDK;
                            end
                            else
                            begin
                                cmd.sort_done = 1'b1;
                            end
                        end
                        default:
                        begin
                            // undefined operation: ignored
                        end
                    endcase
                end
            end
            S_DEQ_WAIT:
            begin
                cmd.deq_done = 1'b1;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.k_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                // datapath handles the final entry of the walk here
                state_next = sts.find ? S_FLUSH : S_IDLE;
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            S_SORT_RDK:
            begin
                cmd.sort_rdk = 1'b1;
                state_next   = S_SORT_LDK;
            end
            S_SORT_LDK:
            begin
                cmd.sort_ldk = 1'b1;
                state_next   = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                cmd.sort_cmp = 1'b1;
                if (sts.m_last)
                begin
                    state_next = S_SORT_WRK;
                end
            end
            S_SORT_WRK:
            begin
                cmd.sort_wrk = 1'b1;
                if (sts.ks_last)
                begin
                    cmd.sort_done = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_SORT_RDK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/sfq_dp.sv -----
// Datapath of the sortable queue: ring pointers, entry RAM, walk and sort
// registers, result register. Depends on sfq_pkg and sfq_ram.
`default_nettype none

module sfq_dp #(
    parameter int DEPTH = sfq_pkg::DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sfq_pkg::req_t request,
    input  wire sfq_pkg::cmd_t cmd,
    output sfq_pkg::sts_t      sts,
    output logic               strobe,
    output sfq_pkg::res_t      result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Ring slot of the entry idx places behind the front
    function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                           input logic [IW-1:0] idx);
        logic [IW:0] s;
        s = {1'b0, base} + {1'b0, idx};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[IW-1:0];
    endfunction

    logic [IW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [IW-1:0]      m_reg, m_next;
    logic [IW-1:0]      rk_reg;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        key_reg;
    logic               rev_reg, find_reg;
    logic               rv_reg;
    logic               held_v_reg, held_v_next;
    logic [4:0]         held_pos_reg, held_pos_next;
    sfq_pkg::res_t      res_reg, res_next;
    logic               strobe_reg, strobe_next;

    logic               we;
    logic [IW-1:0]      waddr, raddr;
    logic [31:0]        wdata, rdata;

    logic [CW-1:0]      count_m1;
    logic               full;
    logic [IW-1:0]      scan_idx;
    logic               swap;
    logic               rlast;
    logic               match;
    logic [4:0]         rpos;

    sfq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Derived values
    assign count_m1 = count_reg - CW'(1);
    assign full     = (count_reg == DEPTH_C);
    assign scan_idx = rev_reg ? IW'(count_m1 - CW'(k_reg)) : k_reg;
    assign swap     = ($signed(a_reg) > $signed(rdata));
    assign rlast    = (CW'(rk_reg) == count_m1);
    assign match    = (rdata == key_reg);
    assign rpos     = 5'(CW'(rk_reg) + CW'(1));

    // Status to controller
    always_comb
    begin
        sts.empty   = (count_reg == '0);
        sts.ge2     = (count_reg >= CW'(2));
        sts.k_last  = (CW'(k_reg) == count_m1);
        sts.m_last  = (CW'(m_reg) == count_m1);
        sts.ks_last = (CW'(k_reg) == count_reg - CW'(2));
        sts.find    = find_reg;
    end

    // RAM write port
    always_comb
    begin
        we    = 1'b0;
        waddr = slot(front_reg, k_reg);
        wdata = a_reg;
        if (cmd.enq && !full)
        begin
            we    = 1'b1;
            waddr = slot(front_reg, IW'(count_reg));
            wdata = request.value;
        end
        else if (cmd.sort_cmp && swap)
        begin
            we    = 1'b1;
            waddr = slot(front_reg, m_reg);
        end
        else if (cmd.sort_wrk)
        begin
            we = 1'b1;
        end
    end

    // RAM read address
    always_comb
    begin
        raddr = front_reg;
        if (cmd.deq_rd)
        begin
            raddr = front_reg;
        end
        else if (cmd.scan_rd)
        begin
            raddr = slot(front_reg, scan_idx);
        end
        else if (cmd.sort_rdk)
        begin
            raddr = slot(front_reg, k_reg);
        end
        else if (cmd.sort_ldk)
        begin
            raddr = slot(front_reg, m_reg);
        end
        else if (cmd.sort_cmp)
        begin
            raddr = slot(front_reg, m_reg + IW'(1));
        end
    end

    // Pointers, counters and sort register
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        a_next     = a_reg;
        if (cmd.enq && !full)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.deq_done)
        begin
            front_next = slot(front_reg, IW'(1));
            count_next = count_m1;
        end
        if (cmd.scan_init || cmd.sort_init)
        begin
            k_next = '0;
        end
        if (cmd.scan_rd || cmd.sort_wrk)
        begin
            k_next = k_reg + IW'(1);
        end
        if (cmd.sort_rdk)
        begin
            m_next = k_reg + IW'(1);
        end
        if (cmd.sort_ldk)
        begin
            a_next = rdata;
        end
        if (cmd.sort_cmp)
        begin
            m_next = m_reg + IW'(1);
            if (swap)
            begin
                a_next = rdata;
            end
        end
    end

    // Result selection; search holds back one match to mark the last
    always_comb
    begin
        res_next      = res_reg;
        strobe_next   = 1'b0;
        held_v_next   = held_v_reg;
        held_pos_next = held_pos_reg;
        if (cmd.scan_init)
        begin
            held_v_next = 1'b0;
        end
        if (cmd.enq)
        begin
            strobe_next = 1'b1;
            res_next    = '{status: full ? sfq_pkg::ST_FULL : sfq_pkg::ST_OK,
                            word: '0, position: '0, last: 1'b1};
        end
        if (cmd.empty_res)
        begin
            strobe_next = 1'b1;
            res_next    = '{status: sfq_pkg::ST_EMPTY, word: '0, position: '0,
                            last: 1'b1};
        end
        if (cmd.sort_done)
        begin
            strobe_next = 1'b1;
            res_next    = '{status: sfq_pkg::ST_OK, word: '0, position: '0,
                            last: 1'b1};
        end
        if (cmd.deq_done)
        begin
            strobe_next = 1'b1;
            res_next    = '{status: sfq_pkg::ST_OK, word: rdata, position: '0,
                            last: 1'b1};
        end
        if (rv_reg)
        begin
            if (!find_reg)
            begin
                strobe_next = 1'b1;
                res_next    = '{status: sfq_pkg::ST_OK, word: rdata, position: '0,
                                last: rlast};
            end
            else if (match)
            begin
                if (held_v_reg)
                begin
                    strobe_next = 1'b1;
                    res_next    = '{status: sfq_pkg::ST_OK, word: '0,
                                    position: held_pos_reg, last: 1'b0};
                end
                held_v_next   = 1'b1;
                held_pos_next = rpos;
            end
        end
        if (cmd.flush)
        begin
            strobe_next = 1'b1;
            if (held_v_reg)
            begin
                res_next = '{status: sfq_pkg::ST_OK, word: '0,
                             position: held_pos_reg, last: 1'b1};
            end
            else
            begin
                res_next = '{status: sfq_pkg::ST_NOTFOUND, word: '0,
                             position: '0, last: 1'b1};
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            rv_reg     <= 1'b0;
            held_v_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            rv_reg     <= cmd.scan_rd;
            held_v_reg <= held_v_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        m_reg        <= m_next;
        a_reg        <= a_next;
        rk_reg       <= k_reg;
        held_pos_reg <= held_pos_next;
        res_reg      <= res_next;
        if (cmd.scan_init)
        begin
            key_reg  <= request.value;
            rev_reg  <= (request.operation == sfq_pkg::OP_REV);
            find_reg <= (request.operation == sfq_pkg::OP_FIND);
        end
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ----- sv/sfq_checker.sv -----
// Port-level checks of the sortable queue, bound to the top level.
// Depends on sfq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfq_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire sfq_pkg::req_t request,
    input wire logic          strobe,
    input wire sfq_pkg::res_t result
);

    logic err_res;
    logic pos_res;
    logic enq_taken;

    // Result and request classes
    assign err_res   = strobe && (result.status != sfq_pkg::ST_OK);
    assign pos_res   = strobe && (result.position != '0);
    assign enq_taken = start && !busy && (request.operation == sfq_pkg::OP_ENQ);

    // Error answers end their run
    `SFQ_ASSERT(a_err_final, err_res |-> result.last)

    // Error answers carry no word and no position
    `SFQ_ASSERT(a_err_zero, err_res |-> (result.word == '0 && result.position == '0))

    // A search match reports a position and no word
    `SFQ_ASSERT(a_pos_word, pos_res |-> (result.word == '0 && result.status == sfq_pkg::ST_OK))

    // Enqueue answers in the next cycle with a single final item
    `SFQ_ASSERT_NEXT(a_enq_answer, enq_taken, strobe && result.last)

endmodule

bind sortable_fifo_queue_with_search_core sfq_checker u_sfq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
);

`default_nettype wire
